>>> design/sbdm_pkg.sv
// Shared types and constants for the block-diagonal matrix-vector multiplier.
`default_nettype none
package sbdm_pkg;

  localparam int MAX_BLOCK = 16;
  localparam int VALUE_W = 32;
  localparam int POS_W = 4;
  localparam int BS_W = 5;
  localparam int FRAC_W = 16;

  localparam logic [BS_W-1:0] BLOCK_SIZE_RESET = 5'd16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ELEM = 1'b1;

  // Control part of a token travelling along the cell chain.
  typedef struct packed {
    logic             valid;
    logic             load;
    logic             close;
    logic [POS_W-1:0] row;
  } tok_t;

endpackage
`default_nettype wire

>>> design/sbdm_if.sv
// Valid/ready channel interfaces for load/element items and for results.
`default_nettype none
interface sbdm_in_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic [sbdm_pkg::POS_W-1:0]          row;
  logic [sbdm_pkg::POS_W-1:0]          col;
  logic signed [sbdm_pkg::VALUE_W-1:0] value;
  logic                                end_of_vector;

  modport source (output valid, opcode, row, col, value, end_of_vector, input ready);
  modport sink (input valid, opcode, row, col, value, end_of_vector, output ready);
endinterface

interface sbdm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sbdm_pkg::VALUE_W-1:0] product;
  logic [sbdm_pkg::POS_W-1:0]          row_in_block;
  logic                                block_done;
  logic                                vector_done;

  modport source (output valid, product, row_in_block, block_done, vector_done, input ready);
  modport sink (input valid, product, row_in_block, block_done, vector_done, output ready);
endinterface
`default_nettype wire

>>> design/sbdm_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module sbdm_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AddrW-1:0]      waddr,
  input  wire logic [Width-1:0]      wdata,
  input  wire logic [AddrW-1:0]      raddr,
  output logic      [Width-1:0]      rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> design/sbdm_cell.sv
// One multiply-accumulate cell: owns one matrix row and one running dot product.
`default_nettype none
module sbdm_cell #(
  parameter int MaxBlock = sbdm_pkg::MAX_BLOCK,
  parameter int RowIdx   = 0,
  parameter int IdxW     = 4,
  parameter int AccW     = 68
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire sbdm_pkg::tok_t                tok_in,
  input  wire logic [IdxW-1:0]               idx_in,
  input  wire logic [sbdm_pkg::VALUE_W-1:0]  val_in,
  output sbdm_pkg::tok_t                     tok_out,
  output logic [IdxW-1:0]                    idx_out,
  output logic [sbdm_pkg::VALUE_W-1:0]       val_out,
  input  wire logic                          shift,
  input  wire logic [AccW-1:0]               acc_in,
  output logic [AccW-1:0]                    acc_out,
  output logic                               done
);
  localparam int VW = sbdm_pkg::VALUE_W;

  sbdm_pkg::tok_t    tok_q;
  logic [IdxW-1:0]   idx_q;
  logic [VW-1:0]     val_q;

  logic              row_we;
  logic [VW-1:0]     coef;

  logic              valid_b;
  logic              first_b;
  logic              close_b;
  logic signed [VW-1:0] elem_b;

  logic              valid_c;
  logic              first_c;
  logic              close_c;
  logic signed [2*VW-1:0] prod_c;

  logic [AccW-1:0]   acc;
  logic [AccW-1:0]   prod_ext;

  // Chain stage: take the neighbour's token every cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q.valid <= 1'b0;
    end else begin
      tok_q.valid <= tok_in.valid;
    end
    tok_q.load  <= tok_in.load;
    tok_q.close <= tok_in.close;
    tok_q.row   <= tok_in.row;
    idx_q       <= idx_in;
    val_q       <= val_in;
  end

  assign tok_out = tok_q;
  assign idx_out = idx_q;
  assign val_out = val_q;

  assign row_we = tok_q.valid && tok_q.load && (32'(tok_q.row) == RowIdx);

  sbdm_ram #(
    .Width (VW),
    .Depth (MaxBlock)
  ) u_row (
    .clk   (clk),
    .we    (row_we),
    .waddr (idx_q),
    .wdata (val_q),
    .raddr (idx_q),
    .rdata (coef)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
      valid_c <= 1'b0;
      done    <= 1'b0;
    end else begin
      valid_b <= tok_q.valid && !tok_q.load;
      valid_c <= valid_b;
      done    <= valid_c && close_c;
    end
    first_b <= (idx_q == '0);
    close_b <= tok_q.close;
    elem_b  <= val_q;
    first_c <= first_b;
    close_c <= close_b;
    prod_c  <= signed'(coef) * elem_b;
  end

  assign prod_ext = {{(AccW-2*VW){prod_c[2*VW-1]}}, prod_c};

  // Restart the sum on the first element of a block; drain moves sums toward cell 0
  always_ff @(posedge clk) begin
    if (shift) begin
      acc <= acc_in;
    end else if (valid_c) begin
      acc <= first_c ? prod_ext : acc + prod_ext;
    end
  end

  assign acc_out = acc;
endmodule
`default_nettype wire

>>> design/shared_block_diag_matvec.sv
// Top level: item intake, block control, cell chain and result register.
// A shared square block of up to MaxBlock rows multiplies a vector block by block,
// in signed Q16.16 with exact sums floored and saturated to 32 bits. Tokens pass
// down a chain of MaxBlock cells, one per matrix row, one cell per cycle; each cell
// keeps its own row of coefficients and its own running sum. Load transactions go
// straight down the chain and vector elements are buffered, one per cycle, while a
// block fills, so a block always meets the coefficients held when it closes. The
// element that closes a block (the block_size-th, or one flagged end_of_vector)
// stops intake while the buffered elements are replayed down the chain one per
// cycle and the last product is summed; then the block_size results leave one per
// cycle as the sink takes them, shifted out of the chain through cell 0, and intake
// resumes as the last result is registered. Writing block_size drops a partly
// filled block. No clearing pass after reset.
`default_nettype none
module shared_block_diag_matvec #(
  parameter int MaxBlock = sbdm_pkg::MAX_BLOCK
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wen,
  input  wire logic [sbdm_pkg::BS_W-1:0]  cfg_wdata,
  sbdm_in_if.sink                         item,
  sbdm_out_if.source                      result
);
  localparam int IdxW = (MaxBlock > 1) ? $clog2(MaxBlock) : 1;
  localparam int CntW = $clog2(MaxBlock + 1);
  localparam int AccW = 2 * sbdm_pkg::VALUE_W + IdxW;
  localparam int VW   = sbdm_pkg::VALUE_W;
  localparam int FW   = sbdm_pkg::FRAC_W;
  localparam int PW   = sbdm_pkg::POS_W;

  typedef enum logic [1:0] {
    S_RUN,
    S_FEED,
    S_WAIT,
    S_DRAIN
  } state_t;

  state_t                    state;
  logic [sbdm_pkg::BS_W-1:0] block_size;
  logic [CntW-1:0]           fill;
  logic [CntW-1:0]           drain_row;
  logic                      vec_end;
  logic [IdxW-1:0]           feed_idx;
  logic [IdxW-1:0]           feed_last;
  logic                      feed_valid;
  logic                      feed_close;
  logic [IdxW-1:0]           feed_pos;

  logic [CntW-1:0]           n_act;
  logic [CntW-1:0]           fill_inc;
  logic                      accept;
  logic                      is_elem;
  logic                      closes;
  logic                      slot_free;
  logic                      shift;
  logic                      last_row;
  logic                      buf_we;
  logic [IdxW-1:0]           buf_waddr;
  logic [VW-1:0]             buf_rdata;

  sbdm_pkg::tok_t            tok_chain [MaxBlock+1];
  logic [IdxW-1:0]           idx_chain [MaxBlock+1];
  logic [VW-1:0]             val_chain [MaxBlock+1];
  logic [AccW-1:0]           acc_chain [MaxBlock+1];
  logic [MaxBlock-1:0]       done_vec;

  logic [AccW-1:0]           acc_sh;
  logic [AccW-32:0]          acc_hi;
  logic [VW-1:0]             sat;

  always_comb begin
    if (block_size == '0) begin
      n_act = CntW'(1);
    end else if (32'(block_size) > MaxBlock) begin
      n_act = CntW'(MaxBlock);
    end else begin
      n_act = CntW'(block_size);
    end
  end

  assign item.ready = (state == S_RUN);
  assign accept     = item.valid && item.ready;
  assign is_elem    = (item.opcode == sbdm_pkg::OP_ELEM);
  assign fill_inc   = fill + CntW'(1);
  assign closes     = (fill_inc == n_act) || item.end_of_vector;
  assign slot_free  = !result.valid || result.ready;
  assign shift      = (state == S_DRAIN) && slot_free;
  assign last_row   = (drain_row == n_act - CntW'(1));
  assign buf_we     = accept && is_elem;
  assign buf_waddr  = IdxW'(fill);

  // Hold the elements of the filling block until it closes
  sbdm_ram #(
    .Width (VW),
    .Depth (MaxBlock)
  ) u_elem (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (item.value),
    .raddr (feed_idx),
    .rdata (buf_rdata)
  );

  // Inject loads as they arrive and replayed elements after a close; drop loads
  // outside the store
  always_comb begin
    tok_chain[0].valid = feed_valid || (accept && !is_elem && (32'(item.col) < MaxBlock)
                                        && (32'(item.row) < MaxBlock));
    tok_chain[0].load  = !feed_valid;
    tok_chain[0].close = feed_valid && feed_close;
    tok_chain[0].row   = item.row;
    idx_chain[0]       = feed_valid ? feed_pos : IdxW'(item.col);
    val_chain[0]       = feed_valid ? buf_rdata : item.value;
  end

  assign acc_chain[MaxBlock] = '0;

  for (genvar r = 0; r < MaxBlock; r++) begin : g_cell
    sbdm_cell #(
      .MaxBlock (MaxBlock),
      .RowIdx   (r),
      .IdxW     (IdxW),
      .AccW     (AccW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok_chain[r]),
      .idx_in  (idx_chain[r]),
      .val_in  (val_chain[r]),
      .tok_out (tok_chain[r+1]),
      .idx_out (idx_chain[r+1]),
      .val_out (val_chain[r+1]),
      .shift   (shift),
      .acc_in  (acc_chain[r+1]),
      .acc_out (acc_chain[r]),
      .done    (done_vec[r])
    );
  end

  // Floor by 2^16, then saturate to 32 bits
  always_comb begin
    acc_sh = AccW'($signed(acc_chain[0]) >>> FW);
    acc_hi = acc_sh[AccW-1:31];
    if ((&acc_hi) || !(|acc_hi)) begin
      sat = acc_sh[VW-1:0];
    end else if (acc_sh[AccW-1]) begin
      sat = {1'b1, {(VW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(VW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_RUN;
      block_size   <= sbdm_pkg::BLOCK_SIZE_RESET;
      fill         <= '0;
      drain_row    <= '0;
      vec_end      <= 1'b0;
      feed_idx     <= '0;
      feed_last    <= '0;
      feed_valid   <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      feed_valid <= (state == S_FEED);
      feed_pos   <= feed_idx;
      feed_close <= (feed_idx == feed_last);
      if (result.valid && result.ready && !shift) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_RUN: begin
          if (cfg_wen) begin
            block_size <= cfg_wdata;
            fill       <= '0;
          end else if (accept && is_elem) begin
            if (closes) begin
              fill      <= '0;
              feed_idx  <= '0;
              feed_last <= IdxW'(fill);
              vec_end   <= item.end_of_vector;
              state     <= S_FEED;
            end else begin
              fill <= fill_inc;
            end
          end
        end
        S_FEED: begin
          if (feed_idx == feed_last) begin
            state <= S_WAIT;
          end else begin
            feed_idx <= feed_idx + IdxW'(1);
          end
        end
        S_WAIT: begin
          if (done_vec[MaxBlock-1]) begin
            drain_row <= '0;
            state     <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (slot_free) begin
            result.valid        <= 1'b1;
            result.product      <= sat;
            result.row_in_block <= PW'(drain_row);
            result.block_done   <= last_row;
            result.vector_done  <= last_row && vec_end;
            if (last_row) begin
              state <= S_RUN;
            end else begin
              drain_row <= drain_row + CntW'(1);
            end
          end
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    fill < n_act)
    else $error("fill count reached block size");

  a_one_close: assert property (@(posedge clk) disable iff (rst)
    $onehot0(done_vec))
    else $error("more than one closing token in the chain");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    done_vec[MaxBlock-1] |-> (state == S_WAIT))
    else $error("block closed while not waiting for it");

  a_block_done_row: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.block_done)
      |-> (result.row_in_block == PW'(n_act - CntW'(1))))
    else $error("block end flagged on wrong row");

  a_vector_done_ends_block: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.vector_done) |-> result.block_done)
    else $error("vector end flagged inside a block");
`endif

endmodule
`default_nettype wire
